/* sv/swasp_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swasp_pkg
// shared types, constants and the slot order of the register write packer
// ----------------------------------------------------------------------------
package swasp_pkg;

   localparam int NUM_SLOTS = 28;
   localparam int SLOT_W    = 5;
   localparam int HEAD_LEN  = 11;
   localparam int POS_W     = 4;

   localparam logic [4:0] MAX_REG_ADDR = 5'h18;
   localparam logic [4:0] CTRL_A       = 5'h04;
   localparam logic [4:0] CTRL_B       = 5'h0b;
   localparam logic [4:0] CTRL_C       = 5'h12;
   localparam logic [4:0] EXTRA_A      = 5'h19;
   localparam logic [4:0] EXTRA_B      = 5'h1a;
   localparam logic [4:0] EXTRA_C      = 5'h1b;

   localparam logic [7:0] SYSEX_START  = 8'hf0;
   localparam logic [7:0] MFR_ID       = 8'h2d;
   localparam logic [7:0] DEV_ID       = 8'h4e;
   localparam logic [7:0] SYSEX_END    = 8'hf7;

   localparam logic [15:0] SEND_THRESHOLD_RST = 16'd6000;
   localparam logic [15:0] TICK_INTERVAL_RST  = 16'd5000;

   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_TICK  = 1'b1;

   localparam logic CSR_SEND_THRESHOLD = 1'b0;
   localparam logic CSR_TICK_INTERVAL  = 1'b1;

   localparam logic [SLOT_W-1:0] SLOT_ORDER [NUM_SLOTS] = '{
      5'd0,  5'd1,  5'd2,  5'd3,  5'd5,  5'd6,  5'd7,  5'd8,  5'd9,  5'd10,
      5'd12, 5'd13, 5'd14, 5'd15, 5'd16, 5'd17, 5'd19, 5'd20, 5'd21, 5'd22,
      5'd23, 5'd24, 5'd4,  5'd11, 5'd18, 5'd25, 5'd26, 5'd27
   };

   typedef struct packed {
      logic        opcode;
      logic [31:0] now_cycle;
      logic [4:0]  reg_addr;
      logic [7:0]  reg_data;
   } swasp_req_type;

   typedef struct packed {
      logic [7:0]  out_byte;
      logic        frame_last;
      logic [31:0] wait_cycles;
   } swasp_rsp_type;

   typedef struct packed {
      logic              is_tick;
      logic              addr_ok;
      logic              is_ctrl;
      logic [SLOT_W-1:0] extra_slot;
      logic [31:0]       now_cycle;
      logic [4:0]        reg_addr;
      logic [7:0]        reg_data;
   } swasp_item_type;

   typedef struct packed {
      logic           valid;
      swasp_item_type item;
   } swasp_queue_type;

endpackage

/* sv/sid_write_to_asid_sysex_packer.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sid_write_to_asid_sysex_packer
// packs timed sound chip register writes into sysex frames
// ----------------------------------------------------------------------------
// A transaction enters a two-entry queue and is then processed by a
// sequencer: a write with no frame passes elapsed time, saturating add,
// threshold check and shadow store, a dropped address ends after the check
// and a tick that is too early ends after the elapsed time is compared.
// A frame adds 11 header bytes, a scan over the 28 shadow file entries (one
// entry per cycle while the result side does not stall a written entry;
// written entries leave as bytes) and one end byte; results leave through
// one output register so a byte waits there while the next is prepared.
module sid_write_to_asid_sysex_packer (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  swasp_pkg::swasp_req_type req_data,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output swasp_pkg::swasp_rsp_type rsp_data,
   input  logic                     csr_psel,
   input  logic                     csr_penable,
   input  logic                     csr_pwrite,
   input  logic [2:0]               csr_paddr,
   input  logic [31:0]              csr_pwdata,
   output logic [31:0]              csr_prdata,
   output logic                     csr_pready
);
   import swasp_pkg::*;

   swasp_queue_type queue;
   logic            pop;
   logic [15:0]     send_threshold_ff, send_threshold_in;
   logic [15:0]     tick_interval_ff, tick_interval_in;
   logic            csr_write;
   logic            csr_index;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_index  = csr_paddr[2];

   always_comb begin
      send_threshold_in = send_threshold_ff;
      tick_interval_in  = tick_interval_ff;
      if (csr_write) begin
         unique case (csr_index)
            CSR_SEND_THRESHOLD: send_threshold_in = csr_pwdata[15:0];
            CSR_TICK_INTERVAL:  tick_interval_in  = csr_pwdata[15:0];
            default:            send_threshold_in = send_threshold_ff;
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         CSR_SEND_THRESHOLD: csr_prdata = {16'b0, send_threshold_ff};
         CSR_TICK_INTERVAL:  csr_prdata = {16'b0, tick_interval_ff};
         default:            csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         send_threshold_ff <= SEND_THRESHOLD_RST;
         tick_interval_ff  <= TICK_INTERVAL_RST;
      end else begin
         send_threshold_ff <= send_threshold_in;
         tick_interval_ff  <= tick_interval_in;
      end
   end

   swasp_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .queue     (queue),
      .pop       (pop)
   );

   swasp_back u_back (
      .clock          (clock),
      .reset          (reset),
      .queue          (queue),
      .pop            (pop),
      .send_threshold (send_threshold_ff),
      .tick_interval  (tick_interval_ff),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_data       (rsp_data)
   );

endmodule

/* sv/swasp_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swasp_front
// accepts transactions, classifies them and holds them in a two-entry queue
// ----------------------------------------------------------------------------
module swasp_front (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  swasp_pkg::swasp_req_type  req_data,
   output swasp_pkg::swasp_queue_type queue,
   input  logic                      pop
);
   import swasp_pkg::*;

   swasp_item_type entry_ff [2];
   swasp_item_type item;
   logic [1:0]     count_ff, count_in;
   logic           wr_ptr_ff, wr_ptr_in;
   logic           rd_ptr_ff, rd_ptr_in;
   logic           push;

   always_comb begin
      item            = '0;
      item.is_tick    = (req_data.opcode == OP_TICK);
      item.addr_ok    = (req_data.reg_addr <= MAX_REG_ADDR);
      item.now_cycle  = req_data.now_cycle;
      item.reg_addr   = req_data.reg_addr;
      item.reg_data   = req_data.reg_data;
      unique case (req_data.reg_addr)
         CTRL_A: begin
            item.is_ctrl    = 1'b1;
            item.extra_slot = EXTRA_A;
         end
         CTRL_B: begin
            item.is_ctrl    = 1'b1;
            item.extra_slot = EXTRA_B;
         end
         CTRL_C: begin
            item.is_ctrl    = 1'b1;
            item.extra_slot = EXTRA_C;
         end
         default: begin
            item.is_ctrl    = 1'b0;
            item.extra_slot = EXTRA_A;
         end
      endcase
   end

   assign req_ready   = (count_ff != 2'd2);
   assign push        = req_valid && req_ready;
   assign queue.valid = (count_ff != 2'd0);
   assign queue.item  = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
      end else begin
         count_ff  <= count_in;
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= item;
      end
   end

endmodule

/* sv/swasp_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swasp_back
// time accounting, shadow register file and sysex frame sequencer
// ----------------------------------------------------------------------------
module swasp_back (
   input  logic                       clock,
   input  logic                       reset,
   input  swasp_pkg::swasp_queue_type queue,
   output logic                       pop,
   input  logic [15:0]                send_threshold,
   input  logic [15:0]                tick_interval,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output swasp_pkg::swasp_rsp_type   rsp_data
);
   import swasp_pkg::*;

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_TIME  = 3'd1;
   localparam logic [2:0] S_CHECK = 3'd2;
   localparam logic [2:0] S_HEAD  = 3'd3;
   localparam logic [2:0] S_DATA  = 3'd4;
   localparam logic [2:0] S_TAIL  = 3'd5;
   localparam logic [2:0] S_STORE = 3'd6;

   logic [2:0]           state_ff, state_in;
   swasp_item_type       item_ff, item_in;
   logic [31:0]          elapsed_ff, elapsed_in;
   logic [31:0]          pending_ff, pending_in;
   logic [31:0]          last_ff, last_in;
   logic [POS_W-1:0]     pos_ff, pos_in;
   logic [SLOT_W-1:0]    scan_ff, scan_in;
   logic [NUM_SLOTS-1:0] written_ff, written_in;
   logic [7:0]           shadow_ff [NUM_SLOTS];
   logic [7:0]           shadow_in [NUM_SLOTS];
   logic                 rsp_valid_ff, rsp_valid_in;
   swasp_rsp_type        rsp_ff, rsp_in;

   logic [NUM_SLOTS-1:0] mask;
   logic [NUM_SLOTS-1:0] msb;
   logic [32:0]          sum;
   logic                 out_free;
   logic                 emit;
   logic                 emit_last;
   logic [7:0]           emit_byte;
   logic [7:0]           head_byte;
   logic [SLOT_W-1:0]    slot;
   logic [7:0]           extra_val;

   always_comb begin
      for (int i = 0; i < NUM_SLOTS; i++) begin
         mask[i] = written_ff[SLOT_ORDER[i]];
         msb[i]  = shadow_ff[SLOT_ORDER[i]][7];
      end
   end

   always_comb begin
      unique case (pos_ff)
         4'd0:    head_byte = SYSEX_START;
         4'd1:    head_byte = MFR_ID;
         4'd2:    head_byte = DEV_ID;
         4'd3:    head_byte = {1'b0, mask[6:0]};
         4'd4:    head_byte = {1'b0, mask[13:7]};
         4'd5:    head_byte = {1'b0, mask[20:14]};
         4'd6:    head_byte = {1'b0, mask[27:21]};
         4'd7:    head_byte = {1'b0, msb[6:0]};
         4'd8:    head_byte = {1'b0, msb[13:7]};
         4'd9:    head_byte = {1'b0, msb[20:14]};
         4'd10:   head_byte = {1'b0, msb[27:21]};
         default: head_byte = '0;
      endcase
   end

   always_comb begin
      unique case (item_ff.extra_slot)
         EXTRA_B: extra_val = shadow_ff[EXTRA_B];
         EXTRA_C: extra_val = shadow_ff[EXTRA_C];
         default: extra_val = shadow_ff[EXTRA_A];
      endcase
   end

   assign slot     = SLOT_ORDER[scan_ff];
   assign sum      = {1'b0, pending_ff} + {1'b0, elapsed_ff};
   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in   = state_ff;
      item_in    = item_ff;
      elapsed_in = elapsed_ff;
      pending_in = pending_ff;
      last_in    = last_ff;
      pos_in     = pos_ff;
      scan_in    = scan_ff;
      written_in = written_ff;
      shadow_in  = shadow_ff;
      pop        = 1'b0;
      emit       = 1'b0;
      emit_last  = 1'b0;
      emit_byte  = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (queue.valid) begin
               pop        = 1'b1;
               item_in    = queue.item;
               elapsed_in = queue.item.now_cycle - last_ff;
               state_in   = S_TIME;
            end
         end
         S_TIME: begin
            if (item_ff.is_tick && (elapsed_ff < {16'b0, tick_interval})) begin
               state_in = S_IDLE;
            end else begin
               pending_in = sum[32] ? '1 : sum[31:0];
               last_in    = item_ff.now_cycle;
               state_in   = S_CHECK;
            end
         end
         S_CHECK: begin
            if (item_ff.is_tick || (pending_ff > {16'b0, send_threshold})) begin
               pos_in   = '0;
               state_in = S_HEAD;
            end else if (item_ff.addr_ok) begin
               state_in = S_STORE;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_HEAD: begin
            if (out_free) begin
               emit      = 1'b1;
               emit_byte = head_byte;
               if (pos_ff == POS_W'(HEAD_LEN - 1)) begin
                  scan_in  = '0;
                  state_in = S_DATA;
               end else begin
                  pos_in = pos_ff + 1'b1;
               end
            end
         end
         S_DATA: begin
            if (!written_ff[slot] || out_free) begin
               emit      = written_ff[slot];
               emit_byte = {1'b0, shadow_ff[slot][6:0]};
               if (scan_ff == SLOT_W'(NUM_SLOTS - 1)) begin
                  state_in = S_TAIL;
               end else begin
                  scan_in = scan_ff + 1'b1;
               end
            end
         end
         S_TAIL: begin
            if (out_free) begin
               emit       = 1'b1;
               emit_last  = 1'b1;
               emit_byte  = SYSEX_END;
               written_in = '0;
               pending_in = '0;
               state_in   = (!item_ff.is_tick && item_ff.addr_ok) ? S_STORE : S_IDLE;
            end
         end
         S_STORE: begin
            if (!written_ff[item_ff.reg_addr]) begin
               shadow_in[item_ff.reg_addr]  = item_ff.reg_data;
               written_in[item_ff.reg_addr] = 1'b1;
            end else if (item_ff.is_ctrl) begin
               if (written_ff[item_ff.extra_slot]) begin
                  shadow_in[item_ff.reg_addr] = extra_val;
               end
               shadow_in[item_ff.extra_slot]  = item_ff.reg_data;
               written_in[item_ff.extra_slot] = 1'b1;
            end else begin
               shadow_in[item_ff.reg_addr] = item_ff.reg_data;
            end
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      if (emit) begin
         rsp_valid_in       = 1'b1;
         rsp_in.out_byte    = emit_byte;
         rsp_in.frame_last  = emit_last;
         rsp_in.wait_cycles = pending_ff;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         pending_ff   <= '0;
         last_ff      <= '0;
         written_ff   <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < NUM_SLOTS; i++) begin
            shadow_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         pending_ff   <= pending_in;
         last_ff      <= last_in;
         written_ff   <= written_in;
         rsp_valid_ff <= rsp_valid_in;
         shadow_ff    <= shadow_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff    <= item_in;
      elapsed_ff <= elapsed_in;
      pos_ff     <= pos_in;
      scan_ff    <= scan_in;
      rsp_ff     <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // frame end clears the written flags and the pending count
   a_tail_clears: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_TAIL && out_free) |=> (written_ff == '0 && pending_ff == '0))
      else $error("flags or pending count not cleared after frame end");

   // the queue is drained only between transactions
   a_pop_idle: assert property (@(posedge clock) disable iff (reset)
      pop |-> (state_ff == S_IDLE && queue.valid))
      else $error("queue popped while busy");

   // a held result is never overwritten
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      emit |-> out_free)
      else $error("frame byte overwrites a pending result");

   // stores only touch legal addresses
   a_store_addr: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_STORE) |-> (item_ff.addr_ok && !item_ff.is_tick))
      else $error("store of a dropped or tick transaction");

   // data scan stays within the shadow file
   a_scan_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DATA) |-> (scan_ff <= SLOT_W'(NUM_SLOTS - 1)))
      else $error("scan index out of range");

endmodule
